FILE: design/afd_pkg.sv
// Shared types, message ids and decode function for the AHRS frame deframer.
`default_nettype none

package afd_pkg;

  // Message id bytes that open a frame
  localparam logic [7:0] ID_MODE_ACK  = 8'h10;
  localparam logic [7:0] ID_EE_READ   = 8'h28;
  localparam logic [7:0] ID_EULER     = 8'h0E;
  localparam logic [7:0] ID_VECT      = 8'h02;
  localparam logic [7:0] ID_RAW_VECT  = 8'h03;
  localparam logic [7:0] ID_EE_WRITE  = 8'h29;

  // Frame kind codes reported on the result channel
  localparam logic [2:0] KIND_MODE_ACK = 3'd0;
  localparam logic [2:0] KIND_EE_READ  = 3'd1;
  localparam logic [2:0] KIND_EULER    = 3'd2;
  localparam logic [2:0] KIND_VECT     = 3'd3;
  localparam logic [2:0] KIND_RAW_VECT = 3'd4;
  localparam logic [2:0] KIND_EE_WRITE = 3'd5;

  // Frame lengths in bytes, id byte included
  localparam logic [4:0] LEN_SHORT = 5'd7;
  localparam logic [4:0] LEN_MID   = 5'd11;
  localparam logic [4:0] LEN_LONG  = 5'd23;

  // Index of the final payload word for each length
  localparam logic [3:0] LAST_WORD_SHORT = 4'd1;
  localparam logic [3:0] LAST_WORD_MID   = 4'd3;
  localparam logic [3:0] LAST_WORD_LONG  = 4'd9;

  typedef struct packed {
    logic       known;
    logic [2:0] kind;
    logic [4:0] len;
    logic [3:0] last_word;
  } id_info_t;

  // Controller to datapath commands
  typedef struct packed {
    logic take;       // input transaction this cycle
    logic check;      // compare checksum, advance tick count
    logic load_err;   // load error result into output register
    logic rd_hi;      // address high byte of current word
    logic rd_lo;      // capture high byte, address low byte
    logic load_word;  // load payload word into output register
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic frame_done; // current byte completes a frame
    logic sum_ok;     // checksum matched
    logic out_free;   // output register can take a result
    logic last_word;  // current word is the final one
  } status_t;

  // Decode an id byte into known flag, kind, length and final word index
  function automatic id_info_t id_decode(input logic [7:0] id);
    id_info_t info;
    info = '0;
    case (id)
      ID_MODE_ACK: info = '{1'b1, KIND_MODE_ACK, LEN_SHORT, LAST_WORD_SHORT};
      ID_EE_READ:  info = '{1'b1, KIND_EE_READ,  LEN_SHORT, LAST_WORD_SHORT};
      ID_EULER:    info = '{1'b1, KIND_EULER,    LEN_MID,   LAST_WORD_MID};
      ID_VECT:     info = '{1'b1, KIND_VECT,     LEN_LONG,  LAST_WORD_LONG};
      ID_RAW_VECT: info = '{1'b1, KIND_RAW_VECT, LEN_LONG,  LAST_WORD_LONG};
      ID_EE_WRITE: info = '{1'b1, KIND_EE_WRITE, LEN_SHORT, LAST_WORD_SHORT};
      default:     info = '0;
    endcase
    return info;
  endfunction

endpackage

`default_nettype wire

FILE: design/afd_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module afd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: design/afd_dpath.sv
// Datapath: frame buffer, running checksum, tick accumulator and output register.
`default_nettype none

module afd_dpath #(
  parameter int FRAME_BYTES_MAX = 32
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire afd_pkg::cmd_t   cmd,
  output afd_pkg::status_t     status,
  input  wire logic [7:0]      rx_byte,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output logic [2:0]           frame_kind,
  output logic                 sum_error,
  output logic [3:0]           word_index,
  output logic signed [15:0]   word_value,
  output logic [31:0]          tick_total,
  output logic                 last
);
  import afd_pkg::*;

  localparam int AW = $clog2(FRAME_BYTES_MAX);

  logic           in_frame;
  logic [4:0]     pos;
  logic [2:0]     kind;
  logic [4:0]     len;
  logic [3:0]     last_word;
  logic [15:0]    sum;
  logic [15:0]    rsum;
  logic [15:0]    tick_new;
  logic [15:0]    prev_tick;
  logic [15:0]    tick_delta;
  logic [31:0]    tick_accum;
  logic [3:0]     widx;
  logic [7:0]     hi_byte;

  id_info_t       info;
  logic           timed;
  logic           ram_we;
  logic [AW-1:0]  ram_waddr;
  logic [AW-1:0]  ram_raddr;
  logic [7:0]     ram_rdata;
  logic [4:0]     word_base;
  logic [4:0]     rd_addr;
  logic           out_free;

  assign info  = id_decode(rx_byte);
  assign timed = (kind inside {KIND_EULER, KIND_VECT, KIND_RAW_VECT});

  // Timer advance wraps at 16 bits before it reaches the 32-bit count
  assign tick_delta = tick_new - prev_tick;

  // Store every byte of the frame, id at address zero
  assign ram_we    = cmd.take && (in_frame || info.known);
  assign ram_waddr = in_frame ? AW'(pos) : '0;

  // Word i sits at bytes 1+2i (high) and 2+2i (low)
  assign word_base = {widx, 1'b0};
  assign rd_addr   = cmd.rd_hi ? (word_base + 5'd1) : (word_base + 5'd2);
  assign ram_raddr = AW'(rd_addr);

  afd_ram #(
    .WIDTH (8),
    .DEPTH (FRAME_BYTES_MAX)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (rx_byte),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign out_free = !out_valid || out_ready;

  // Report status to the controller
  always_comb begin
    status.frame_done = in_frame && (pos == len - 5'd1);
    status.sum_ok     = (sum == rsum);
    status.out_free   = out_free;
    status.last_word  = (widx == last_word);
  end

  // Hold frame state, tick count and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame   <= 1'b0;
      prev_tick  <= '0;
      tick_accum <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cmd.take) begin
        if (!in_frame) begin
          in_frame <= info.known;
        end else if (pos == len - 5'd1) begin
          in_frame <= 1'b0;
        end
      end
      if (cmd.check && status.sum_ok && timed) begin
        tick_accum <= tick_accum + {16'h0000, tick_delta};
        prev_tick  <= tick_new;
      end
      if (cmd.load_err || cmd.load_word) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Accumulate checksum and capture timer and trailing words
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      if (!in_frame) begin
        pos       <= 5'd1;
        kind      <= info.kind;
        len       <= info.len;
        last_word <= info.last_word;
        sum       <= {8'h00, rx_byte};
      end else begin
        pos <= pos + 5'd1;
        if (pos <= len - 5'd3) begin
          sum <= sum + (pos[0] ? {rx_byte, 8'h00} : {8'h00, rx_byte});
        end
        if (pos == len - 5'd4) begin
          tick_new[15:8] <= rx_byte;
        end
        if (pos == len - 5'd3) begin
          tick_new[7:0] <= rx_byte;
        end
        if (pos == len - 5'd2) begin
          rsum[15:8] <= rx_byte;
        end
        if (pos == len - 5'd1) begin
          rsum[7:0] <= rx_byte;
        end
      end
    end

    // Walk the payload words
    if (cmd.check) begin
      widx <= '0;
    end else if (cmd.load_word) begin
      widx <= widx + 4'd1;
    end
    if (cmd.rd_lo) begin
      hi_byte <= ram_rdata;
    end

    // Load the output register
    if (cmd.load_err) begin
      frame_kind <= kind;
      sum_error  <= 1'b1;
      word_index <= '0;
      word_value <= '0;
      tick_total <= tick_accum;
      last       <= 1'b1;
    end else if (cmd.load_word) begin
      frame_kind <= kind;
      sum_error  <= 1'b0;
      word_index <= widx;
      word_value <= {hi_byte, ram_rdata};
      tick_total <= tick_accum;
      last       <= status.last_word;
    end
  end

endmodule

`default_nettype wire

FILE: design/afd_ctrl.sv
// Controller: sequences byte intake, checksum verdict and word emission.
`default_nettype none

module afd_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire afd_pkg::status_t status,
  output afd_pkg::cmd_t         cmd
);
  import afd_pkg::*;

  typedef enum logic [5:0] {
    S_RX   = 6'b000001,
    S_CHK  = 6'b000010,
    S_ERR  = 6'b000100,
    S_RDHI = 6'b001000,
    S_RDLO = 6'b010000,
    S_LOAD = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = (state == S_RX);

  // Decode commands from the current state
  always_comb begin
    cmd           = '0;
    cmd.take      = in_ready && in_valid;
    cmd.check     = (state == S_CHK);
    cmd.load_err  = (state == S_ERR) && status.out_free;
    cmd.rd_hi     = (state == S_RDHI);
    cmd.rd_lo     = (state == S_RDLO);
    cmd.load_word = (state == S_LOAD) && status.out_free;
  end

  // Advance the state machine
  always_comb begin
    state_next = state;
    case (state)
      S_RX: begin
        if (cmd.take && status.frame_done) begin
          state_next = S_CHK;
        end
      end
      S_CHK: begin
        state_next = status.sum_ok ? S_RDHI : S_ERR;
      end
      S_ERR: begin
        if (status.out_free) begin
          state_next = S_RX;
        end
      end
      S_RDHI: begin
        state_next = S_RDLO;
      end
      S_RDLO: begin
        state_next = S_LOAD;
      end
      S_LOAD: begin
        if (status.out_free) begin
          state_next = status.last_word ? S_RX : S_RDHI;
        end
      end
      default: begin
        state_next = S_RX;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_RX;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

FILE: design/ahrs_frame_deframer_unit.sv
// Top level of the AHRS frame deframer: controller plus datapath.
`default_nettype none

// Byte-serial deframer for an attitude sensor link. Each input transaction
// carries one received byte; while hunting, bytes that are not a known
// message id are dropped, and an id byte opens a frame of 7, 11 or 23 bytes
// that is buffered in a byte RAM while a 16-bit checksum is summed on the fly.
// Bytes are taken one per cycle while the controller is in its receive
// state. The byte that closes a frame is followed by a check state; a bad
// frame then yields a single error result, a good one yields its payload
// words, each through a high-byte read, a low-byte read and a load state,
// since the RAM has a single registered read port. No input is taken from
// the closing byte until the final result is loaded into the output register.
module ahrs_frame_deframer_unit #(
  parameter int FRAME_BYTES_MAX = 32
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [7:0]          rx_byte,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [2:0]               frame_kind,
  output logic                     sum_error,
  output logic [3:0]               word_index,
  output logic signed [15:0]       word_value,
  output logic [31:0]              tick_total,
  output logic                     last
);
  import afd_pkg::*;

  cmd_t    cmd;
  status_t status;

  afd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  afd_dpath #(
    .FRAME_BYTES_MAX (FRAME_BYTES_MAX)
  ) u_dpath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .rx_byte    (rx_byte),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .frame_kind (frame_kind),
    .sum_error  (sum_error),
    .word_index (word_index),
    .word_value (word_value),
    .tick_total (tick_total),
    .last       (last)
  );

endmodule

`default_nettype wire

FILE: design/afd_checker.sv
// Port-level checks for the AHRS frame deframer, bound to the top level.
`default_nettype none

module afd_checker (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire logic [2:0]         frame_kind,
  input wire logic               sum_error,
  input wire logic [3:0]         word_index,
  input wire logic signed [15:0] word_value,
  input wire logic [31:0]        tick_total,
  input wire logic               last
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(word_value) && $stable(last))
    else $error("stalled result changed");

  // Error result stands alone with empty word
  a_err_form: assert property (@(posedge clk) disable iff (rst)
    out_valid && sum_error |-> last && word_index == 4'd0 && word_value == 16'sd0)
    else $error("malformed error result");

  // Final word index matches a frame length
  a_last_idx: assert property (@(posedge clk) disable iff (rst)
    out_valid && last && !sum_error |->
      word_index == 4'd1 || word_index == 4'd3 || word_index == 4'd9)
    else $error("final word index does not fit a frame length");

  // Keep tick count fixed within a frame
  a_tick_frame: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last |=> $stable(tick_total))
    else $error("tick count changed inside a frame");

endmodule

bind ahrs_frame_deframer_unit afd_checker u_afd_checker (.*);

`default_nettype wire
